// ===== rtl/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants of the smooth parameter ramp
// item formats, register codes, fixed-point widths and the blend polynomial
// coefficients
// ----------------------------------------------------------------------------
package spr_pkg;

    // fixed-point formats
    localparam int PHASE_FRAC_BITS = 30;
    localparam int NUM_VALUES      = 6;
    localparam int VAL_IDX_W       = $clog2(NUM_VALUES);
    localparam int VALUE_W         = 32;
    localparam int PERIOD_W        = 31;
    localparam int STEP_W          = 31;
    localparam int PHASE_W         = 32;
    localparam int POW_W           = PHASE_FRAC_BITS;
    localparam int BLEND_W         = PHASE_FRAC_BITS + 1;

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;
    localparam logic [BLEND_W-1:0] BLEND_ONE = BLEND_W'(1) << PHASE_FRAC_BITS;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 31;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEP          = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_LOWER_BOUND = CFG_INDEX_W'(1);
    localparam logic [STEP_W-1:0]      RAMP_STEP_RESET        = STEP_W'(1073742);
    localparam logic [PERIOD_W-1:0]    PERIOD_LOWER_BOUND_RESET = PERIOD_W'(65536);

    // command codes
    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_RETARGET = 1'b1;

    // digit-serial multiplier
    localparam int DIGIT_W    = 8;
    localparam int MUL_A_W    = VALUE_W + 1;
    localparam int MUL_B_W    = 32;
    localparam int MUL_STEPS  = MUL_B_W / DIGIT_W;
    localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
    localparam int MUL_HI_W   = MUL_A_W + 1;
    localparam int MUL_SUM_W  = MUL_A_W + DIGIT_W + 1;
    localparam int ROUND_STEP = (PHASE_FRAC_BITS - 1) / DIGIT_W;
    localparam int ROUND_BIT  = (PHASE_FRAC_BITS - 1) % DIGIT_W;

    // blend accumulator
    localparam int COEF_W = 11;
    localparam int ACC_W  = POW_W + COEF_W + 1;
    localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1) << PHASE_FRAC_BITS;

    localparam int POW_IDX_W = 4;
    localparam logic [POW_IDX_W-1:0] POW_FIRST = POW_IDX_W'(2);
    localparam logic [POW_IDX_W-1:0] POW_LAST  = POW_IDX_W'(9);

    typedef logic [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic                      command;
        logic signed [VALUE_W-1:0] new_period;
        logic signed [VALUE_W-1:0] new_center_x;
        logic signed [VALUE_W-1:0] new_center_z;
        logic signed [VALUE_W-1:0] new_semi_a;
        logic signed [VALUE_W-1:0] new_semi_b;
        logic signed [VALUE_W-1:0] new_tilt;
        logic                      direction_forward;
    } req_item_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]       cur_period;
        logic signed [VALUE_W-1:0] cur_center_x;
        logic signed [VALUE_W-1:0] cur_center_z;
        logic signed [VALUE_W-1:0] cur_semi_a;
        logic signed [VALUE_W-1:0] cur_semi_b;
        logic signed [VALUE_W-1:0] cur_tilt;
        logic                      ramping;
    } rsp_item_t;

    // coefficient of s^k in 126s^5 - 420s^6 + 540s^7 - 315s^8 + 70s^9
    function automatic logic signed [COEF_W-1:0] blend_coef(input logic [POW_IDX_W-1:0] k);
        logic signed [COEF_W-1:0] c;
        case (k)
            POW_IDX_W'(5): c = COEF_W'(126);
            POW_IDX_W'(6): c = -COEF_W'(420);
            POW_IDX_W'(7): c = COEF_W'(540);
            POW_IDX_W'(8): c = -COEF_W'(315);
            POW_IDX_W'(9): c = COEF_W'(70);
            default:       c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/spr_if.sv =====
// ----------------------------------------------------------------------------
// spr_if: request and result channels of the smooth parameter ramp
// valid/ready handshake, an item moves when both are high at a clock edge
// ----------------------------------------------------------------------------
interface spr_req_if;
    import spr_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface spr_rsp_if;
    import spr_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/spr_digit_mul.sv =====
// ----------------------------------------------------------------------------
// spr_digit_mul: digit-serial signed by unsigned multiplier
// one 8-bit digit of b per cycle, product rounded half up and shifted right
// by the phase fraction width
// ----------------------------------------------------------------------------
module spr_digit_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [spr_pkg::MUL_A_W-1:0]  a,
    input  logic [spr_pkg::MUL_B_W-1:0]         b,
    output logic                                done,
    output logic [spr_pkg::VALUE_W-1:0]         product
);
    import spr_pkg::*;

    logic signed [MUL_A_W-1:0]   a_reg;
    logic [MUL_B_W-1:0]          b_reg;
    logic signed [MUL_HI_W-1:0]  hi_reg;
    logic [MUL_B_W-1:0]          lo_reg;
    logic [MUL_CNT_W-1:0]        cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [DIGIT_W-1:0]          digit;
    logic signed [MUL_SUM_W-1:0] part;
    logic signed [MUL_SUM_W-1:0] rnd;
    logic signed [MUL_SUM_W-1:0] sum;
    logic signed [MUL_HI_W-1:0]  hi_next;
    logic [MUL_B_W-1:0]          lo_next;
    logic [MUL_HI_W+MUL_B_W-1:0] full;

    assign digit = b_reg[DIGIT_W-1:0];
    assign part  = MUL_SUM_W'(a_reg) * MUL_SUM_W'($signed({1'b0, digit}));
    // rounding half folded in at the digit that carries its weight
    assign rnd   = (cnt_reg == MUL_CNT_W'(ROUND_STEP)) ?
                   (MUL_SUM_W'(1) << ROUND_BIT) : '0;
    assign sum     = MUL_SUM_W'(hi_reg) + part + rnd;
    assign hi_next = MUL_HI_W'(sum >>> DIGIT_W);
    assign lo_next = {sum[DIGIT_W-1:0], lo_reg[MUL_B_W-1:DIGIT_W]};

    assign full    = {hi_reg, lo_reg};
    assign product = full[PHASE_FRAC_BITS +: VALUE_W];
    assign done    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + MUL_CNT_W'(1);
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            b_reg  <= b;
            hi_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg  <= b_reg >> DIGIT_W;
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

endmodule

// ===== rtl/smooth_parameter_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// smooth_parameter_ramp_unit: ninth-order smoothstep ramp of six parameters
// moves period, center x/z, semi-axes and tilt from start to target values
// ----------------------------------------------------------------------------
// usage
//   request channel: one item per control tick (command tick) or per new set
//   of parameters (command retarget); result channel: one item per request,
//   carrying the six current values and the ramping flag after that item
//   config port: ramp_step and period_lower_bound, written while idle
// sequencing
//   retarget, tick with no ramp, and the tick that snaps to the targets:
//   S_PUT loads the result, then the unit is idle for the next request
//   tick inside a ramp: the next request is taken only after the result;
//   the single digit-serial multiplier builds s^2..s^9 one after another
//   (4 digit steps and a capture each), S_SUM and S_CLAMP sum and clamp the
//   blend, then 6 value products follow (issue, 4 digit steps, write-back)
// reset
//   all values, starts, targets and the phase clear to zero, no ramp runs,
//   registers return to their reset values, result channel empty
// stall
//   the result sits in an output register; the next request is still taken
//   and its result waits in the final state until the register frees up
// ----------------------------------------------------------------------------
module smooth_parameter_ramp_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    spr_req_if.sink                           request,
    spr_rsp_if.source                         result,
    input  logic                              cfg_we,
    input  logic [spr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import spr_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a request
    localparam logic [2:0] S_POW   = 3'd1;  // building s^2 .. s^9
    localparam logic [2:0] S_SUM   = 3'd2;  // last blend term accumulates
    localparam logic [2:0] S_CLAMP = 3'd3;  // clamp blend to [0, 1]
    localparam logic [2:0] S_VGO   = 3'd4;  // issue one value product
    localparam logic [2:0] S_VAL   = 3'd5;  // wait for it, write the value
    localparam logic [2:0] S_PUT   = 3'd6;  // hand the result item over

    // magnitude saturated to 31 bits
    function automatic logic [PERIOD_W-1:0] mag_sat(input logic signed [VALUE_W-1:0] x);
        logic [VALUE_W-1:0] neg;
        logic [PERIOD_W-1:0] m;
        neg = VALUE_W'(-x);
        if (!x[VALUE_W-1])
            m = x[PERIOD_W-1:0];
        else if (neg[VALUE_W-1])
            m = '1;
        else
            m = neg[PERIOD_W-1:0];
        return m;
    endfunction

    // configuration
    logic [STEP_W-1:0]    ramp_step_reg;
    logic [PERIOD_W-1:0]  period_lb_reg;

    // ramp state
    logic [2:0]           state_reg, state_next;
    value_t               cur_reg   [NUM_VALUES];
    value_t               cur_next  [NUM_VALUES];
    value_t               start_reg [NUM_VALUES];
    value_t               start_next[NUM_VALUES];
    value_t               tgt_reg   [NUM_VALUES];
    value_t               tgt_next  [NUM_VALUES];
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic                 active_reg, active_next;

    // blend evaluation
    logic [POW_IDX_W-1:0] k_reg, k_next;
    logic [POW_W-1:0]     pow_reg, pow_next;
    logic [POW_IDX_W-1:0] pow_k_reg, pow_k_next;
    logic                 pend_reg, pend_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [BLEND_W-1:0]   blend_reg, blend_next;
    logic [VAL_IDX_W-1:0] idx_reg, idx_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    rsp_item_t            out_item_reg, out_item_next;

    // datapath
    logic                 req_accept;
    logic                 slot_free;
    logic                 mul_start;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic                 mul_done;
    logic [VALUE_W-1:0]   mul_product;
    logic signed [MUL_A_W-1:0] diff;
    logic signed [COEF_W-1:0]  coef;
    logic signed [ACC_W-1:0]   term;
    logic [BLEND_W-1:0]   blend_clamped;
    logic [PERIOD_W-1:0]  per_mag;
    logic [PERIOD_W-1:0]  semi_a_mag;
    logic [PERIOD_W-1:0]  semi_b_mag;
    logic [PERIOD_W-1:0]  per_target;
    logic [VALUE_W-1:0]   semi_a_target;

    assign request.ready  = (state_reg == S_IDLE);
    assign req_accept     = request.valid && request.ready;
    assign slot_free      = !out_valid_reg || result.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_item_reg;

    // retarget: period magnitude bounded below, semi-axis a takes the direction
    assign per_mag       = mag_sat(request.payload.new_period);
    assign semi_a_mag    = mag_sat(request.payload.new_semi_a);
    assign semi_b_mag    = mag_sat(request.payload.new_semi_b);
    assign per_target    = (per_mag < period_lb_reg) ? period_lb_reg : per_mag;
    assign semi_a_target = request.payload.direction_forward ?
                           VALUE_W'(semi_a_mag) : (VALUE_W'(0) - VALUE_W'(semi_a_mag));

    // target minus start of the value being worked on
    assign diff = MUL_A_W'($signed(tgt_reg[idx_reg])) -
                  MUL_A_W'($signed(start_reg[idx_reg]));

    // one blend term per finished power
    assign coef = blend_coef(pow_k_reg);
    assign term = ACC_W'(coef) * ACC_W'($signed({1'b0, pow_reg}));

    // negative or zero sums clamp to zero, sums above one clamp to one
    always_comb
    begin
        if (acc_reg[ACC_W-1] || (acc_reg == '0))
            blend_clamped = '0;
        else if (acc_reg > ACC_ONE)
            blend_clamped = BLEND_ONE;
        else
            blend_clamped = acc_reg[BLEND_W-1:0];
    end

    spr_digit_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        start_next     = start_reg;
        tgt_next       = tgt_reg;
        phase_next     = phase_reg;
        active_next    = active_reg;
        k_next         = k_reg;
        pow_next       = pow_reg;
        pow_k_next     = pow_k_reg;
        pend_next      = 1'b0;
        acc_next       = acc_reg;
        blend_next     = blend_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_item_next  = out_item_reg;
        mul_start      = 1'b0;
        mul_a          = MUL_A_W'(mul_product[POW_W-1:0]);
        mul_b          = MUL_B_W'(phase_reg[POW_W-1:0]);

        // accumulate the power produced in the previous cycle
        if (pend_reg)
            acc_next = acc_reg + term;

        unique case (state_reg)
            S_IDLE:
            begin
                mul_a = MUL_A_W'(phase_reg[POW_W-1:0]);
                if (req_accept)
                begin
                    state_next = S_PUT;
                    if (request.payload.command == CMD_RETARGET)
                    begin
                        start_next  = cur_reg;
                        tgt_next[0] = VALUE_W'(per_target);
                        tgt_next[1] = request.payload.new_center_x;
                        tgt_next[2] = request.payload.new_center_z;
                        tgt_next[3] = semi_a_target;
                        tgt_next[4] = VALUE_W'(semi_b_mag);
                        tgt_next[5] = request.payload.new_tilt;
                        phase_next  = '0;
                        active_next = 1'b1;
                    end
                    else if (active_reg && (phase_reg >= PHASE_ONE))
                    begin
                        // ramp done: snap, phase stays
                        cur_next    = tgt_reg;
                        active_next = 1'b0;
                    end
                    else if (active_reg)
                    begin
                        state_next = S_POW;
                        mul_start  = 1'b1;
                        k_next     = POW_FIRST;
                        acc_next   = '0;
                        idx_next   = '0;
                    end
                end
            end
            S_POW:
            begin
                if (mul_done)
                begin
                    pow_next   = mul_product[POW_W-1:0];
                    pow_k_next = k_reg;
                    pend_next  = 1'b1;
                    if (k_reg == POW_LAST)
                    begin
                        state_next = S_SUM;
                    end
                    else
                    begin
                        k_next    = k_reg + POW_IDX_W'(1);
                        mul_start = 1'b1;
                    end
                end
            end
            S_SUM:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                blend_next = blend_clamped;
                state_next = S_VGO;
            end
            S_VGO:
            begin
                mul_a      = diff;
                mul_b      = MUL_B_W'(blend_reg);
                mul_start  = 1'b1;
                state_next = S_VAL;
            end
            S_VAL:
            begin
                if (mul_done)
                begin
                    cur_next[idx_reg] = start_reg[idx_reg] + mul_product;
                    if (idx_reg == VAL_IDX_W'(NUM_VALUES - 1))
                    begin
                        phase_next = phase_reg + PHASE_W'(ramp_step_reg);
                        state_next = S_PUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + VAL_IDX_W'(1);
                        state_next = S_VGO;
                    end
                end
            end
            S_PUT:
            begin
                if (slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.cur_period   = cur_reg[0][PERIOD_W-1:0];
                    out_item_next.cur_center_x = cur_reg[1];
                    out_item_next.cur_center_z = cur_reg[2];
                    out_item_next.cur_semi_a   = cur_reg[3];
                    out_item_next.cur_semi_b   = cur_reg[4];
                    out_item_next.cur_tilt     = cur_reg[5];
                    out_item_next.ramping      = active_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // config writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_step_reg <= RAMP_STEP_RESET;
            period_lb_reg <= PERIOD_LOWER_BOUND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RAMP_STEP:          ramp_step_reg <= cfg_data[STEP_W-1:0];
                REG_PERIOD_LOWER_BOUND: period_lb_reg <= cfg_data[PERIOD_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '{default: '0};
            start_reg     <= '{default: '0};
            tgt_reg       <= '{default: '0};
            phase_reg     <= '0;
            active_reg    <= 1'b0;
            k_reg         <= '0;
            pow_k_reg     <= '0;
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            start_reg     <= start_next;
            tgt_reg       <= tgt_next;
            phase_reg     <= phase_next;
            active_reg    <= active_next;
            k_reg         <= k_next;
            pow_k_reg     <= pow_k_next;
            pend_reg      <= pend_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pow_reg      <= pow_next;
        acc_reg      <= acc_next;
        blend_reg    <= blend_next;
        out_item_reg <= out_item_next;
    end

endmodule

// ===== rtl/spr_checker.sv =====
// ----------------------------------------------------------------------------
// spr_checker: port-level assertions for the smooth parameter ramp
// watches the request and result channels, bound to the top level
// ----------------------------------------------------------------------------
module spr_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_ready,
    input  logic               req_command,
    input  logic               res_valid,
    input  logic               res_ready,
    input  spr_pkg::rsp_item_t res_payload
);
    import spr_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_payload)))
        else $error("result item changed while stalled");

    // one item at a time: ready drops right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while the previous item is in flight");

    // a finished item waiting on a stalled result keeps the request side closed
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready && !req_ready) |=> !req_ready)
        else $error("request reopened while a result is stuck");

    // a retarget into an empty result slot is answered, ramping, once S_PUT has loaded the result register
    a_retarget_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_command == CMD_RETARGET) && !res_valid)
        |-> ##2 (res_valid && res_payload.ramping))
        else $error("retarget result missing or not ramping");

endmodule

bind smooth_parameter_ramp_unit spr_checker u_spr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (request.valid),
    .req_ready   (request.ready),
    .req_command (request.payload.command),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_payload (result.payload)
);

// ===== tb/sv/spr_ramp_checker.sv =====
// ----------------------------------------------------------------------------
// spr_ramp_checker: result checker of the smooth parameter ramp
// follows the config port and both channels, keeps its own copy of the six
// values, their starts and targets and the ramp phase, predicts the result of
// every accepted request item and compares it with the next result item
// ----------------------------------------------------------------------------
module spr_ramp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    spr_req_if                              request_ch,
    spr_rsp_if                              result_ch,
    input  logic                            cfg_we,
    input  logic [spr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              outstanding
);
    import spr_pkg::*;

    localparam longint HALF_LSB   = longint'(1) << (PHASE_FRAC_BITS - 1);
    localparam int     REPORT_MAX = 10;

    logic [STEP_W-1:0]         step_r;
    logic [PERIOD_W-1:0]       floor_r;
    logic signed [VALUE_W-1:0] now_v   [NUM_VALUES];
    logic signed [VALUE_W-1:0] start_v [NUM_VALUES];
    logic signed [VALUE_W-1:0] goal_v  [NUM_VALUES];
    logic [PHASE_W-1:0]        phase_r;
    logic                      active_r;
    rsp_item_t                 predicted_params_q [$];

    // |x| with the most negative input held at the largest positive value
    function automatic logic [VALUE_W-1:0] clipped_magnitude(input logic signed [VALUE_W-1:0] x);
        if (x == 32'sh8000_0000)
            return 32'h7FFF_FFFF;
        return (x < 0) ? -x : x;
    endfunction

    // 126s^5 - 420s^6 + 540s^7 - 315s^8 + 70s^9, each power rounded, clamped to [0, 1]
    function automatic longint smoothstep9(input logic [PHASE_W-1:0] s);
        longint unsigned pw [1:9];
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned w;
        int              k;
        pw[1] = s;
        for (k = 2; k <= 9; k++)
            pw[k] = (pw[k-1] * pw[1] + HALF_LSB) >> PHASE_FRAC_BITS;
        pos = 64'd126 * pw[5] + 64'd540 * pw[7] + 64'd70 * pw[9];
        neg = 64'd420 * pw[6] + 64'd315 * pw[8];
        w = (pos > neg) ? pos - neg : 64'd0;
        if (w > PHASE_ONE)
            w = PHASE_ONE;
        return longint'(w);
    endfunction

    task automatic advance_trajectory(input req_item_t it, output rsp_item_t res);
        logic [VALUE_W-1:0] per_mag;
        logic [VALUE_W-1:0] a_mag;
        longint             w;
        longint             base;
        longint             span;
        int                 i;
        if (it.command == CMD_RETARGET)
        begin
            per_mag = clipped_magnitude(it.new_period);
            a_mag   = clipped_magnitude(it.new_semi_a);
            for (i = 0; i < NUM_VALUES; i++)
                start_v[i] = now_v[i];
            goal_v[0] = (per_mag < VALUE_W'(floor_r)) ? VALUE_W'(floor_r) : per_mag;
            goal_v[1] = it.new_center_x;
            goal_v[2] = it.new_center_z;
            goal_v[3] = it.direction_forward ? a_mag : -a_mag;
            goal_v[4] = clipped_magnitude(it.new_semi_b);
            goal_v[5] = it.new_tilt;
            phase_r   = '0;
            active_r  = 1'b1;
        end
        else if (active_r)
        begin
            if (phase_r >= PHASE_ONE)
            begin
                // snap to the targets, phase left as it is
                now_v    = goal_v;
                active_r = 1'b0;
            end
            else
            begin
                w = smoothstep9(phase_r);
                for (i = 0; i < NUM_VALUES; i++)
                begin
                    base     = start_v[i];
                    span     = longint'(goal_v[i]) - base;
                    now_v[i] = VALUE_W'(base + ((span * w + HALF_LSB) >>> PHASE_FRAC_BITS));
                end
                phase_r = phase_r + PHASE_W'(step_r);
            end
        end
        res.cur_period   = now_v[0][PERIOD_W-1:0];
        res.cur_center_x = now_v[1];
        res.cur_center_z = now_v[2];
        res.cur_semi_a   = now_v[3];
        res.cur_semi_b   = now_v[4];
        res.cur_tilt     = now_v[5];
        res.ramping      = active_r;
    endtask

    function automatic string fmt_params(input rsp_item_t r);
        return $sformatf("per %h cx %h cz %h a %h b %h tilt %h ramping %b",
                         r.cur_period, r.cur_center_x, r.cur_center_z,
                         r.cur_semi_a, r.cur_semi_b, r.cur_tilt, r.ramping);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_item_t want;
        rsp_item_t got;
        rsp_item_t fresh;
        if (!rst_n)
        begin
            fail_count = 0;
            step_r     = RAMP_STEP_RESET;
            floor_r    = PERIOD_LOWER_BOUND_RESET;
            for (int i = 0; i < NUM_VALUES; i++)
            begin
                now_v[i]   = '0;
                start_v[i] = '0;
                goal_v[i]  = '0;
            end
            phase_r  = '0;
            active_r = 1'b0;
            predicted_params_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RAMP_STEP:          step_r  = cfg_data;
                    REG_PERIOD_LOWER_BOUND: floor_r = cfg_data;
                    default:                ;
                endcase
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.payload;
                if (predicted_params_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: result item with none expected: %s",
                                 $realtime, fmt_params(got));
                end
                else
                begin
                    want = predicted_params_q.pop_front();
                    if (got.cur_period !== want.cur_period ||
                        got.cur_center_x !== want.cur_center_x ||
                        got.cur_center_z !== want.cur_center_z ||
                        got.cur_semi_a !== want.cur_semi_a ||
                        got.cur_semi_b !== want.cur_semi_b ||
                        got.cur_tilt !== want.cur_tilt ||
                        got.ramping !== want.ramping)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                                     $realtime, fmt_params(want), fmt_params(got));
                    end
                end
            end
            if (request_ch.valid && request_ch.ready)
            begin
                advance_trajectory(request_ch.payload, fresh);
                predicted_params_q.push_back(fresh);
            end
        end
        outstanding = predicted_params_q.size();
    end

endmodule

// ===== tb/sv/tb_smooth_parameter_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// tb_smooth_parameter_ramp_unit: testbench of the smooth parameter ramp
// a directed run through saturations, clamping, snapping, restarts and the
// step extremes, then random tick and retarget items under six register
// settings with random idling on both channels and one long result stall;
// a checker beside the block predicts and compares every result item
// ----------------------------------------------------------------------------
module tb_smooth_parameter_ramp_unit;
    import spr_pkg::*;

    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 11;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int IDLE_PCT        = 26;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 212;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 100;

    // index outside the register map, the block has to drop such writes
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(3);
    // phase step of one whole ramp per tick
    localparam logic [STEP_W-1:0] STEP_FULL = STEP_W'(1) << PHASE_FRAC_BITS;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int outstanding;
    int cycle_count  = 0;
    bit calm         = 1'b0;   // no idling on either side while set
    bit hold_request = 1'b0;   // asks the receiver for one long stall
    bit hold_taken   = 1'b0;   // the long stall has been started
    int hold_left    = 0;

    spr_req_if request_ch ();
    spr_rsp_if result_ch ();

    smooth_parameter_ramp_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    spr_ramp_checker ramp_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .request_ch  (request_ch),
        .result_ch   (result_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #HALF_PERIOD clk = ~clk;

    // runaway guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** smooth_parameter_ramp_unit: FAILED **");
            $finish;
        end
    end

    // result side: random ready, open while calm, and one long hold-off
    // counted here so the block fills up and pushes back on the request side
    initial
    begin : receiver
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (calm)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // full-range words in four of ten draws, the rest extremes and small values
    function automatic logic [31:0] noise_word();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return {{12{r[19]}}, r[19:0]};
            default: return r;
        endcase
    endfunction

    // a tick carries random parameter fields too, they must be ignored
    function automatic req_item_t make_item(input logic cmd);
        req_item_t it;
        it.command           = cmd;
        it.new_period        = noise_word();
        it.new_center_x      = noise_word();
        it.new_center_z      = noise_word();
        it.new_semi_a        = noise_word();
        it.new_semi_b        = noise_word();
        it.new_tilt          = noise_word();
        it.direction_forward = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic req_item_t directed_retarget(
        input logic [31:0] per,
        input logic [31:0] cx,
        input logic [31:0] cz,
        input logic [31:0] a,
        input logic [31:0] b,
        input logic [31:0] tilt,
        input logic        fwd
    );
        req_item_t it;
        it.command           = CMD_RETARGET;
        it.new_period        = per;
        it.new_center_x      = cx;
        it.new_center_z      = cz;
        it.new_semi_a        = a;
        it.new_semi_b        = b;
        it.new_tilt          = tilt;
        it.direction_forward = fwd;
        return it;
    endfunction

    // starts and ends on a falling edge; valid stays high after the item
    // so back-to-back items need no drop in between
    task automatic offer(input req_item_t it);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            request_ch.valid <= 1'b0;
            @(negedge clk);
        end
        request_ch.payload <= it;
        request_ch.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!request_ch.ready);
        @(negedge clk);
    endtask

    // register writes only once every result item is back
    task automatic program_regs(input logic [STEP_W-1:0]   step,
                                input logic [PERIOD_W-1:0] floor_val);
        request_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RAMP_STEP;
        cfg_data  <= step;
        @(negedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(negedge clk);
        cfg_index <= REG_PERIOD_LOWER_BOUND;
        cfg_data  <= floor_val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                  ph;
        int                  n;
        int                  retarget_pct;
        logic [STEP_W-1:0]   step;
        logic [PERIOD_W-1:0] floor_val;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        request_ch.valid   = 1'b0;
        request_ch.payload = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part, reset register values first
        // tick with no ramp running: values stay, ramping low
        offer(make_item(CMD_TICK));
        // most negative period, semi-axes saturate, a turned negative
        offer(directed_retarget(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        repeat (2) offer(make_item(CMD_TICK));

        // whole ramp in one step, no period floor
        program_regs(STEP_FULL, '0);
        // opposite extremes, zero period sits on the floor
        offer(directed_retarget(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        // blend of zero, then the snap to the targets, then an idle tick
        repeat (3) offer(make_item(CMD_TICK));
        // negative period magnitude, positive a flipped by the direction flag
        offer(directed_retarget(32'hFFFB_0000, 32'h0012_8000, 32'hFFF0_4000,
                                32'h0003_0000, 32'hFFFE_0000, 32'h0000_C90F, 1'b0));
        offer(make_item(CMD_TICK));
        // retarget in the middle of a ramp restarts from present values
        offer(directed_retarget(32'h0040_0000, 32'hFF80_0000, 32'h0100_0000,
                                32'h0002_0000, 32'h0005_0000, 32'hFFFF_3000, 1'b1));
        repeat (3) offer(make_item(CMD_TICK));

        // smallest step and the highest period floor
        program_regs(STEP_W'(1), '1);
        offer(directed_retarget(32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                32'h0001_0000, 32'h0001_0000, 32'h0000_0001, 1'b1));
        repeat (3) offer(make_item(CMD_TICK));

        // zero step: the phase never moves and the ramp never ends
        program_regs('0, PERIOD_LOWER_BOUND_RESET);
        offer(make_item(CMD_RETARGET));
        repeat (3) offer(make_item(CMD_TICK));

        // step just under one: the second tick sees a phase close to one
        program_regs(STEP_FULL - STEP_W'(1), PERIOD_W'($urandom));
        offer(make_item(CMD_RETARGET));
        repeat (3) offer(make_item(CMD_TICK));

        // ---- random part, one register setting per phase
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    step      = STEP_FULL >> 4;
                    floor_val = PERIOD_W'($urandom_range(0, 1 << 20));
                end
                1:
                begin
                    step      = STEP_FULL;
                    floor_val = '1;
                end
                2:
                begin
                    step      = STEP_W'($urandom_range(STEP_FULL / 50, STEP_FULL / 8));
                    floor_val = '0;
                end
                3:
                begin
                    step      = STEP_FULL - STEP_W'(1);
                    floor_val = PERIOD_W'($urandom);
                end
                4:
                begin
                    step      = STEP_W'($urandom_range(1 << 24, 1 << 28));
                    floor_val = PERIOD_LOWER_BOUND_RESET;
                end
                default:
                begin
                    step      = STEP_W'($urandom_range(1 << 26, 1 << 29));
                    floor_val = PERIOD_W'($urandom);
                end
            endcase
            program_regs(step, floor_val);
            // rare retargets let ramps run to the end, frequent ones cut them short
            retarget_pct = $urandom_range(3, 20);
            // one phase runs with both sides always willing
            calm = (ph == 3);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long result stall while items keep coming
                if (ph == 2 && n == 60)
                    hold_request = 1'b1;
                offer(make_item(($urandom_range(0, 99) < retarget_pct) ?
                                CMD_RETARGET : CMD_TICK));
            end
            calm = 1'b0;
        end

        // ---- drain and verdict
        request_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** smooth_parameter_ramp_unit: PASSED **");
        else
            $display("** smooth_parameter_ramp_unit: FAILED **");
        $finish;
    end

endmodule
